>>> rtl/pmv_pkg.sv
// Shared types and constants for the population statistics block.
package pmv_pkg;

	localparam int SUM_W = 32;
	localparam int SQ_W  = 47;
	localparam int VAR_W = 31;
	localparam int OUT_W = 16;
	localparam int CNT_OUT_W = 17;
	localparam int DIV_W = 64;
	localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

	typedef enum logic [3:0] {
		ST_ACC,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_SQ,
		ST_NEED_GO,
		ST_NEED_WAIT,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		OP_MEAN,
		OP_NEED,
		OP_VAR
	} div_op_t;

	typedef struct packed {
		logic    acc;
		logic    div_start;
		logic    div_cap;
		div_op_t div_op;
		logic    sq_mul;
		logic    root_init;
		logic    root_step;
		logic    load_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic root_last;
		logic out_busy;
	} status_t;

endpackage

>>> rtl/pmv_div.sv
// Restoring divider that produces one quotient bit per cycle.
module pmv_div #(
	parameter int CW = 17
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [pmv_pkg::DIV_W-1:0] dividend,
	input  logic [CW-1:0]          divisor,
	output logic [pmv_pkg::DIV_W-1:0] quot,
	output logic [CW-1:0]          rem,
	output logic                   done
);
	import pmv_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [5:0]        cnt_q;
	logic [DIV_W-1:0]  dq_q;
	logic [CW-1:0]     rem_q;
	logic [CW-1:0]     dvs_q;
	logic [CW:0]       r2;
	logic [CW:0]       diff;
	logic              ge;

	assign r2   = {rem_q, dq_q[DIV_W-1]};
	assign ge   = r2 >= {1'b0, dvs_q};
	assign diff = r2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[CW-1:0] : r2[CW-1:0];
		end
	end

	assign quot = dq_q;
	assign rem  = rem_q;
	assign done = done_q;

endmodule

>>> rtl/pmv_dp.sv
// Datapath: accumulators, working registers, divider, square root and output register.
module pmv_dp #(
	parameter int MAX_COUNT    = 65536,
	parameter int SAMPLE_WIDTH = 16,
	parameter int CW           = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pmv_pkg::cmd_t               cmd,
	output pmv_pkg::status_t            status,
	input  logic [SAMPLE_WIDTH-1:0]     sample,
	input  logic                        last_sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [pmv_pkg::OUT_W-1:0]   mean_value,
	output logic [pmv_pkg::VAR_W-1:0]   variance_value,
	output logic [pmv_pkg::OUT_W-1:0]   std_deviation,
	output logic [pmv_pkg::CNT_OUT_W-1:0] sample_count,
	output logic                        too_many
);
	import pmv_pkg::*;

	logic [CW-1:0]        count_q;
	logic [SUM_W-1:0]     sum_q;
	logic [SQ_W-1:0]      sqsum_q;
	logic                 ovf_q;

	logic signed [SUM_W-1:0] xs;
	logic signed [63:0]   xsq;
	logic                 room;
	logic [CW-1:0]        count_n;
	logic [SUM_W-1:0]     sum_n;
	logic [SQ_W-1:0]      sqsum_n;
	logic                 ovf_n;

	logic [CW-1:0]        n_q;
	logic [SUM_W-1:0]     s_q;
	logic [SQ_W-1:0]      ssq_q;
	logic                 ovw_q;
	logic [DIV_W-1:0]     sq2_q;
	logic [DIV_W-1:0]     need_q;
	logic [OUT_W-1:0]     mean_q;
	logic [VAR_W-1:0]     var_q;
	logic [OUT_W-1:0]     root_q;
	logic [3:0]           bit_q;

	logic                 neg;
	logic [SUM_W-1:0]     mag;
	logic [DIV_W-1:0]     dividend;
	logic [DIV_W-1:0]     quot;
	logic [CW-1:0]        rem;
	logic [DIV_W-1:0]     ssq_ext;
	logic [OUT_W-1:0]     trial;
	logic [2*OUT_W-1:0]   trial_sq;

	logic                 out_valid_q;
	logic [OUT_W-1:0]     mean_out_q;
	logic [VAR_W-1:0]     var_out_q;
	logic [OUT_W-1:0]     sd_out_q;
	logic [CNT_OUT_W-1:0] cnt_out_q;
	logic                 tm_out_q;

	always_comb begin
		xs      = SUM_W'(signed'(sample));
		xsq     = 64'(xs) * 64'(xs);
		room    = count_q < CW'(MAX_COUNT);
		count_n = room ? count_q + CW'(1) : count_q;
		sum_n   = room ? sum_q + xs : sum_q;
		sqsum_n = room ? sqsum_q + xsq[SQ_W-1:0] : sqsum_q;
		ovf_n   = ovf_q | ~room;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.acc) begin
			if (last_sample) begin
				count_q <= '0;
				sum_q   <= '0;
				sqsum_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_n;
				sum_q   <= sum_n;
				sqsum_q <= sqsum_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	assign neg     = s_q[SUM_W-1];
	assign mag     = neg ? -s_q : s_q;
	assign ssq_ext = DIV_W'(ssq_q);

	always_comb begin
		case (cmd.div_op)
			OP_MEAN: dividend = DIV_W'(mag);
			OP_NEED: dividend = sq2_q;
			OP_VAR:  dividend = (ssq_ext >= need_q) ? ssq_ext - need_q : '0;
			default: dividend = '0;
		endcase
	end

	pmv_div #(.CW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (n_q),
		.quot     (quot),
		.rem      (rem),
		.done     (status.div_done)
	);

	assign trial    = root_q | (OUT_W'(1) << bit_q);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk) begin
		if (cmd.acc && last_sample) begin
			n_q   <= count_n;
			s_q   <= sum_n;
			ssq_q <= sqsum_n;
			ovw_q <= ovf_n;
		end
		if (cmd.sq_mul) begin
			sq2_q <= DIV_W'(mag) * DIV_W'(mag);
		end
		if (cmd.div_cap) begin
			case (cmd.div_op)
				OP_MEAN: mean_q <= neg ? -quot[OUT_W-1:0] : quot[OUT_W-1:0];
				OP_NEED: need_q <= quot + DIV_W'(rem != '0);
				OP_VAR:  var_q  <= (quot > DIV_W'(VAR_MAX)) ? VAR_MAX : quot[VAR_W-1:0];
				default: ;
			endcase
		end
		if (cmd.root_init) begin
			root_q <= '0;
			bit_q  <= 4'd15;
		end else if (cmd.root_step) begin
			if (trial_sq <= (2*OUT_W)'(var_q)) begin
				root_q <= trial;
			end
			bit_q <= bit_q - 4'd1;
		end
		if (cmd.load_out) begin
			mean_out_q <= mean_q;
			var_out_q  <= var_q;
			sd_out_q   <= root_q;
			cnt_out_q  <= CNT_OUT_W'(n_q);
			tm_out_q   <= ovw_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.root_last = bit_q == 4'd0;
	assign status.out_busy  = out_valid_q & result_stall;

	assign result_valid   = out_valid_q;
	assign mean_value     = mean_out_q;
	assign variance_value = var_out_q;
	assign std_deviation  = sd_out_q;
	assign sample_count   = cnt_out_q;
	assign too_many       = tm_out_q;

endmodule

>>> rtl/pmv_ctrl.sv
// Controller state machine that sequences accumulation and the final computation.
module pmv_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	input  logic              last_sample,
	output logic              sample_stall,
	input  pmv_pkg::status_t  status,
	output pmv_pkg::cmd_t     cmd
);
	import pmv_pkg::*;

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_ACC: begin
				if (sample_valid && last_sample) state_n = ST_MEAN_GO;
			end
			ST_MEAN_GO:   state_n = ST_MEAN_WAIT;
			ST_MEAN_WAIT: begin
				if (status.div_done) state_n = ST_SQ;
			end
			ST_SQ:        state_n = ST_NEED_GO;
			ST_NEED_GO:   state_n = ST_NEED_WAIT;
			ST_NEED_WAIT: begin
				if (status.div_done) state_n = ST_VAR_GO;
			end
			ST_VAR_GO:    state_n = ST_VAR_WAIT;
			ST_VAR_WAIT: begin
				if (status.div_done) state_n = ST_ROOT_INIT;
			end
			ST_ROOT_INIT: state_n = ST_ROOT;
			ST_ROOT: begin
				if (status.root_last) state_n = ST_OUT;
			end
			ST_OUT: begin
				if (!status.out_busy) state_n = ST_ACC;
			end
			default:      state_n = ST_ACC;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.div_op   = OP_MEAN;
		sample_stall = state_q != ST_ACC;
		case (state_q)
			ST_ACC:       cmd.acc = sample_valid;
			ST_MEAN_GO:   cmd.div_start = 1'b1;
			ST_MEAN_WAIT: cmd.div_cap = status.div_done;
			ST_SQ:        cmd.sq_mul = 1'b1;
			ST_NEED_GO: begin
				cmd.div_op    = OP_NEED;
				cmd.div_start = 1'b1;
			end
			ST_NEED_WAIT: begin
				cmd.div_op  = OP_NEED;
				cmd.div_cap = status.div_done;
			end
			ST_VAR_GO: begin
				cmd.div_op    = OP_VAR;
				cmd.div_start = 1'b1;
			end
			ST_VAR_WAIT: begin
				cmd.div_op  = OP_VAR;
				cmd.div_cap = status.div_done;
			end
			ST_ROOT_INIT: cmd.root_init = 1'b1;
			ST_ROOT:      cmd.root_step = 1'b1;
			ST_OUT:       cmd.load_out = !status.out_busy;
			default:      cmd = '0;
		endcase
	end

endmodule

>>> rtl/population_mean_variance_sdev.sv
// Top level of the population mean, variance and standard deviation block.
// Samples are taken one per cycle while a stream accumulates. After the word
// marked last, the input is stalled while a shared 64-step divider runs
// three times (mean, rounded-up square of the sum over n, and variance) and
// a 16-step root search finds the standard deviation; a finished result then
// sits in the output register while the next stream accumulates.
module population_mean_variance_sdev #(
	parameter int MAX_COUNT    = 65536,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [SAMPLE_WIDTH-1:0]       sample,
	input  logic                          last_sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [pmv_pkg::OUT_W-1:0]     mean_value,
	output logic [pmv_pkg::VAR_W-1:0]     variance_value,
	output logic [pmv_pkg::OUT_W-1:0]     std_deviation,
	output logic [pmv_pkg::CNT_OUT_W-1:0] sample_count,
	output logic                          too_many
);
	import pmv_pkg::*;

	localparam int CW = $clog2(MAX_COUNT + 1);

	cmd_t    cmd;
	status_t status;

	pmv_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.last_sample  (last_sample),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	pmv_dp #(
		.MAX_COUNT    (MAX_COUNT),
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.CW           (CW)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.sample         (sample),
		.last_sample    (last_sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.mean_value     (mean_value),
		.variance_value (variance_value),
		.std_deviation  (std_deviation),
		.sample_count   (sample_count),
		.too_many       (too_many)
	);

endmodule

>>> rtl/pmv_chk.sv
// Port-level checker for the statistics block and its bind statement.
module pmv_chk #(
	parameter int MAX_COUNT = 65536
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          sample_valid,
	input logic                          sample_stall,
	input logic                          last_sample,
	input logic                          result_valid,
	input logic                          result_stall,
	input logic [pmv_pkg::OUT_W-1:0]     mean_value,
	input logic [pmv_pkg::VAR_W-1:0]     variance_value,
	input logic [pmv_pkg::OUT_W-1:0]     std_deviation,
	input logic [pmv_pkg::CNT_OUT_W-1:0] sample_count,
	input logic                          too_many
);
	import pmv_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(mean_value))
		else $error("Stalled result word was dropped or changed.");

	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> 32'(std_deviation) * 32'(std_deviation) <= 32'(variance_value))
		else $error("Standard deviation squared exceeds the variance.");

	a_last_stall: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && !sample_stall && last_sample |=> sample_stall)
		else $error("Input not stalled after the last word of a stream.");

	a_too_many: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && too_many |-> sample_count == CNT_OUT_W'(MAX_COUNT))
		else $error("Overflow flagged with a count below the limit.");

endmodule

bind population_mean_variance_sdev pmv_chk #(
	.MAX_COUNT (MAX_COUNT)
) u_pmv_chk (.*);

>>> test/pmv_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares the statistics results of each sample stream.
module pmv_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	input  logic                          sample_stall,
	input  logic [15:0]                   sample,
	input  logic                          last_sample,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic [pmv_pkg::OUT_W-1:0]     mean_value,
	input  logic [pmv_pkg::VAR_W-1:0]     variance_value,
	input  logic [pmv_pkg::OUT_W-1:0]     std_deviation,
	input  logic [pmv_pkg::CNT_OUT_W-1:0] sample_count,
	input  logic                          too_many,
	output int                            fails,
	output int                            pending
);
	import pmv_pkg::*;

	localparam int FULL_COUNT = 65536;

	typedef struct packed {
		logic [OUT_W-1:0]     mean;
		logic [VAR_W-1:0]     variance;
		logic [OUT_W-1:0]     sdev;
		logic [CNT_OUT_W-1:0] count;
		logic                 dropped;
	} stats_t;

	stats_t stats_q[$];
	logic [16:0]    n_acc;
	logic [SUM_W-1:0] sum_acc;
	logic [SQ_W-1:0]  sq_acc;
	logic           dropped_acc;

	function automatic longint unsigned isqrt(input longint unsigned v);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic stats_t finish_stream(input logic [16:0] n_in,
			input logic [SUM_W-1:0] sum_in, input logic [SQ_W-1:0] sq_in,
			input logic dropped_in);
		stats_t r;
		longint s, mean;
		longint unsigned n, mag, sq2, need, v, sd;
		n = (n_in == 0) ? 1 : n_in;
		s = longint'(signed'(sum_in));
		mean = s / longint'(n);
		mag = (s < 0) ? -s : s;
		sq2 = mag * mag;
		need = sq2 / n + ((sq2 % n) != 0 ? 1 : 0);
		if (longint'(sq_in) < need)
			v = 0;
		else
			v = (longint'(sq_in) - need) / n;
		if (v > VAR_MAX)
			v = VAR_MAX;
		sd = isqrt(v);
		r.mean = mean[OUT_W-1:0];
		r.variance = v[VAR_W-1:0];
		r.sdev = sd[OUT_W-1:0];
		r.count = n[CNT_OUT_W-1:0];
		r.dropped = dropped_in;
		return r;
	endfunction

	assign pending = stats_q.size();

	always @(posedge clk or negedge arst_n) begin
		stats_t got, want;
		logic [16:0]      n_nx;
		logic [SUM_W-1:0] sum_nx;
		logic [SQ_W-1:0]  sq_nx;
		logic             drop_nx;
		longint           x;
		if (!arst_n) begin
			n_acc <= 0;
			sum_acc <= 0;
			sq_acc <= 0;
			dropped_acc <= 0;
			fails <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				n_nx = n_acc;
				sum_nx = sum_acc;
				sq_nx = sq_acc;
				drop_nx = dropped_acc;
				x = longint'(signed'(sample));
				if (n_acc < FULL_COUNT) begin
					n_nx = n_acc + 17'd1;
					sum_nx = sum_acc + x[SUM_W-1:0];
					sq_nx = sq_acc + SQ_W'(x * x);
				end else begin
					drop_nx = 1'b1;
				end
				if (last_sample) begin
					stats_q.insert(stats_q.size(),
						finish_stream(n_nx, sum_nx, sq_nx, drop_nx));
					n_nx = 0;
					sum_nx = 0;
					sq_nx = 0;
					drop_nx = 0;
				end
				n_acc <= n_nx;
				sum_acc <= sum_nx;
				sq_acc <= sq_nx;
				dropped_acc <= drop_nx;
			end
			if (result_valid && !result_stall) begin
				got = '{mean_value, variance_value, std_deviation, sample_count, too_many};
				if (stats_q.size() == 0) begin
					if (fails < 10)
						$display("Unexpected result word: %p", got);
					fails <= fails + 1;
				end else begin
					want = stats_q.pop_front();
					if (got !== want) begin
						if (fails < 10)
							$display("Mismatch: expected %p, got %p", want, got);
						fails <= fails + 1;
					end
				end
			end
		end
	end

endmodule

>>> test/population_mean_variance_sdev_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives sample streams and result stalls, and reports the verdict.
module population_mean_variance_sdev_tb;
	import pmv_pkg::*;

	logic                 clk = 0;
	logic                 arst_n = 0;
	logic                 sample_valid = 0;
	logic                 sample_stall;
	logic [15:0]          sample = 0;
	logic                 last_sample = 0;
	logic                 result_valid;
	logic                 result_stall = 0;
	logic [OUT_W-1:0]     mean_value;
	logic [VAR_W-1:0]     variance_value;
	logic [OUT_W-1:0]     std_deviation;
	logic [CNT_OUT_W-1:0] sample_count;
	logic                 too_many;
	int                   fails, pending;
	int                   words_sent = 0;
	int                   results_taken = 0;

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	population_mean_variance_sdev dut (.*);
	pmv_checker checker_i (.*);

	task automatic send_word(input logic [15:0] value, input logic is_last, input int gap);
		if (gap > 0) begin
			sample_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1;
		sample <= value;
		last_sample <= is_last;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		words_sent++;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_stream(input int len, input int max_gap);
		for (int i = 0; i < len; i++)
			send_word(pick_sample(), i == len - 1, $urandom_range(0, max_gap));
	endtask

	initial begin
		int k;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			k = (results_taken == 6) ? 700 : $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0 && results_taken != 6)
				k = 0;
			if (k > 0) begin
				result_stall <= 1;
				repeat (k) @(posedge clk);
				result_stall <= 0;
			end
			@(posedge clk);
			while (!result_valid)
				@(posedge clk);
			results_taken++;
		end
	end

	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int len, gmax;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_word(16'h7fff, 1, 0);
		send_word(16'h8000, 1, 2);
		send_word(16'h0000, 1, 0);
		send_word(16'h7fff, 0, 0);
		send_word(16'h8000, 1, 0);
		send_word(16'h5555, 0, 1);
		send_word(16'haaaa, 0, 0);
		send_word(16'h0001, 0, 3);
		send_word(16'hffff, 1, 0);
		for (int i = 0; i < 8; i++)
			send_word(16'h0100, i == 7, 0);
		send_word(16'h1234, 0, 0);
		send_word(16'hedcb, 1, 0);
		while (words_sent < 1900) begin
			case ($urandom_range(0, 9))
				0: len = 1;
				1: len = $urandom_range(100, 300);
				default: len = $urandom_range(2, 20);
			endcase
			gmax = ($urandom_range(0, 3) == 0) ? 0 : 8;
			send_stream(len, gmax);
		end
		sample_valid <= 0;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> sim.f
rtl/pmv_pkg.sv
rtl/pmv_div.sv
rtl/pmv_dp.sv
rtl/pmv_ctrl.sv
rtl/population_mean_variance_sdev.sv
rtl/pmv_chk.sv
test/pmv_checker.sv
test/population_mean_variance_sdev_tb.sv
